// ----- rtl/sbm_pkg.sv -----
`default_nettype none
package sbm_pkg;

  localparam int SBM_MEM_WORDS = 16384;
  localparam int SBM_WORD_BITS = 32;
  localparam int SBM_OP_LAST   = 38;

  typedef enum logic [5:0] {
    OP_LEA   = 6'd0,  OP_IMM  = 6'd1,  OP_JMP = 6'd2,  OP_JSR = 6'd3,
    OP_BZ    = 6'd4,  OP_BNZ  = 6'd5,  OP_ENTER = 6'd6, OP_ADJ = 6'd7,
    OP_LEAVE = 6'd8,  OP_LI   = 6'd9,  OP_LC  = 6'd10, OP_SI  = 6'd11,
    OP_SC    = 6'd12, OP_PSH  = 6'd13, OP_OR  = 6'd14, OP_XOR = 6'd15,
    OP_AND   = 6'd16, OP_EQ   = 6'd17, OP_NE  = 6'd18, OP_LT  = 6'd19,
    OP_GT    = 6'd20, OP_LE   = 6'd21, OP_GE  = 6'd22, OP_SHL = 6'd23,
    OP_SHR   = 6'd24, OP_ADD  = 6'd25, OP_SUB = 6'd26, OP_MUL = 6'd27,
    OP_DIV   = 6'd28, OP_MOD  = 6'd29, OP_SYS_FIRST = 6'd30, OP_SYS_LAST = 6'd37,
    OP_EXIT  = 6'd38
  } opcode_t;

  typedef enum logic [2:0] {
    ST_RUN   = 3'd0,
    ST_EXIT  = 3'd1,
    ST_DIVZ  = 3'd2,
    ST_SYS   = 3'd3,
    ST_BADOP = 3'd4,
    ST_ADDR  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_START = 2'd1,
    REQ_STEP  = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    K_SIMPLE, K_PUSH, K_LEAVE, K_LOAD, K_SI, K_SC, K_MUL, K_DIV, K_SYS, K_EXIT
  } kind_t;

  typedef enum logic [1:0] {
    MD_MUL = 2'd0,
    MD_DIV = 2'd1,
    MD_MOD = 2'd2
  } md_op_t;

  // commands from controller to datapath
  typedef struct packed {
    logic write_req;
    logic start_req;
    logic nop_req;
    logic begin_step;
    logic take_op;
    logic take_imm;
    logic take_x;
    logic exec;
    logic leave_bp;
    logic leave_pc;
    logic load_data;
    logic sc_merge;
    logic iter_end;
    logic commit;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic  running;
    logic  pc_ok;
    logic  op_fault;
    logic  op_imm;
    logic  op_x;
    logic  exec_bad;
    logic  leave_bad;
    kind_t kind;
    logic  iter_done;
  } stat_t;

  function automatic kind_t op_kind(input logic [5:0] op);
    kind_t k;
    k = K_SIMPLE;
    if (op == OP_JSR || op == OP_ENTER || op == OP_PSH) k = K_PUSH;
    else if (op == OP_LEAVE) k = K_LEAVE;
    else if (op == OP_LI || op == OP_LC) k = K_LOAD;
    else if (op == OP_SI) k = K_SI;
    else if (op == OP_SC) k = K_SC;
    else if (op == OP_MUL) k = K_MUL;
    else if (op == OP_DIV || op == OP_MOD) k = K_DIV;
    else if (op >= OP_SYS_FIRST && op <= OP_SYS_LAST) k = K_SYS;
    else if (op == OP_EXIT) k = K_EXIT;
    return k;
  endfunction

  function automatic logic op_has_imm(input logic [5:0] op);
    return op <= OP_ADJ;
  endfunction

  function automatic logic op_needs_x(input logic [5:0] op);
    return op == OP_LEAVE || op == OP_SI || op == OP_SC || op == OP_EXIT ||
           (op >= OP_OR && op <= OP_MOD);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sbm_muldiv.sv -----
`default_nettype none
module sbm_muldiv
  import sbm_pkg::*;
#(
  parameter int WORD_BITS = SBM_WORD_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire md_op_t               mode,
  input  wire logic [WORD_BITS-1:0] lhs,
  input  wire logic [WORD_BITS-1:0] rhs,
  output logic                      done,
  output logic [WORD_BITS-1:0]      result
);

  localparam int CW = $clog2(WORD_BITS);

  logic                 busy;
  logic [CW-1:0]        cnt;
  md_op_t               mode_r;
  logic                 neg_q, neg_r;
  logic [WORD_BITS-1:0] acc, opa, opb, rem;
  logic [WORD_BITS-1:0] rem_sh;

  // one bit of product or quotient per cycle
  always_comb begin
    rem_sh = {rem[WORD_BITS-2:0], opa[WORD_BITS-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(WORD_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      acc    <= '0;
      rem    <= '0;
      neg_q  <= lhs[WORD_BITS-1] ^ rhs[WORD_BITS-1];
      neg_r  <= lhs[WORD_BITS-1];
      if (mode == MD_MUL) begin
        opa <= lhs;
        opb <= rhs;
      end else begin
        opa <= lhs[WORD_BITS-1] ? -lhs : lhs;
        opb <= rhs[WORD_BITS-1] ? -rhs : rhs;
      end
    end else if (busy) begin
      if (mode_r == MD_MUL) begin
        if (opb[0]) acc <= acc + opa;
        opa <= opa << 1;
        opb <= opb >> 1;
      end else if (rem_sh >= opb) begin
        rem <= rem_sh - opb;
        opa <= {opa[WORD_BITS-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        opa <= {opa[WORD_BITS-2:0], 1'b0};
      end
    end
  end

  // sign correction of the result
  always_comb begin
    unique case (mode_r)
      MD_MUL:  result = acc;
      MD_DIV:  result = neg_q ? -opa : opa;
      default: result = neg_r ? -rem : rem;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/sbm_ctrl.sv -----
`default_nettype none
module sbm_ctrl
  import sbm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire logic [1:0] req_type,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_OPF    = 12'b0000_0000_0010,
    S_IMM    = 12'b0000_0000_0100,
    S_XRD    = 12'b0000_0000_1000,
    S_EXEC   = 12'b0000_0001_0000,
    S_LV1    = 12'b0000_0010_0000,
    S_LV2    = 12'b0000_0100_0000,
    S_LD     = 12'b0000_1000_0000,
    S_SCM    = 12'b0001_0000_0000,
    S_ITER   = 12'b0010_0000_0000,
    S_COMMIT = 12'b0100_0000_0000,
    S_DONE   = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;
  logic   accept, out_free;

  always_comb begin
    accept   = in_valid && (state == S_IDLE);
    out_free = !out_valid || !out_stall;
    in_stall = (state != S_IDLE);
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DONE;
          unique case (req_t'(req_type))
            REQ_WRITE: cmd.write_req = 1'b1;
            REQ_START: cmd.start_req = 1'b1;
            REQ_STEP: begin
              cmd.begin_step = 1'b1;
              if (stat.running && stat.pc_ok) state_next = S_OPF;
            end
            default: cmd.nop_req = 1'b1;
          endcase
        end
      end
      S_OPF: begin
        cmd.take_op = 1'b1;
        priority if (stat.op_fault) state_next = S_DONE;
        else if (stat.op_imm)       state_next = S_IMM;
        else if (stat.op_x)         state_next = S_XRD;
        else                        state_next = S_EXEC;
      end
      S_IMM: begin
        cmd.take_imm = 1'b1;
        state_next   = S_EXEC;
      end
      S_XRD: begin
        cmd.take_x = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.exec_bad) begin
          state_next = S_DONE;
        end else begin
          unique case (stat.kind)
            K_LEAVE:      state_next = S_LV1;
            K_LOAD:       state_next = S_LD;
            K_SC:         state_next = S_SCM;
            K_MUL, K_DIV: state_next = S_ITER;
            default:      state_next = S_COMMIT;
          endcase
        end
      end
      S_LV1: begin
        cmd.leave_bp = 1'b1;
        state_next   = stat.leave_bad ? S_DONE : S_LV2;
      end
      S_LV2: begin
        cmd.leave_pc = 1'b1;
        state_next   = S_COMMIT;
      end
      S_LD: begin
        cmd.load_data = 1'b1;
        state_next    = S_COMMIT;
      end
      S_SCM: begin
        cmd.sc_merge = 1'b1;
        state_next   = S_COMMIT;
      end
      S_ITER: begin
        if (stat.iter_done) begin
          cmd.iter_end = 1'b1;
          state_next   = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load)    out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sbm_datapath.sv -----
`default_nettype none
module sbm_datapath
  import sbm_pkg::*;
#(
  parameter int MEM_WORDS = SBM_MEM_WORDS,
  parameter int WORD_BITS = SBM_WORD_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic [13:0] word_index,
  input  wire logic signed [31:0] write_value,
  output logic [15:0]      program_counter,
  output logic signed [31:0] accumulator,
  output logic [15:0]      stack_pointer,
  output logic [15:0]      frame_pointer,
  output logic [2:0]       run_status,
  output logic signed [31:0] exit_value,
  output logic [5:0]       executed_opcode,
  output logic [31:0]      steps_taken
);

  localparam int WB   = WORD_BITS;
  localparam int BPW  = WORD_BITS / 8;
  localparam int BOFF = $clog2(BPW);
  localparam int IDX  = $clog2(MEM_WORDS);
  localparam int AW   = (WORD_BITS > 24) ? WORD_BITS : 24;
  localparam logic [AW-1:0] ADDR_LIMIT = AW'(MEM_WORDS * BPW);
  localparam logic [15:0]   STEP = 16'(BPW);

  function automatic logic in_range(input logic [AW-1:0] a);
    return a < ADDR_LIMIT;
  endfunction

  // configuration registers
  logic [15:0] entry_address, stack_top_address;

  // machine state
  logic [15:0]   pc, sp, bp;
  logic [WB-1:0] acc, exitv;
  logic [31:0]   steps;
  status_t       status;
  logic [5:0]    opx;

  // working copies for the instruction in flight
  logic [15:0]   wpc, wsp, wbp;
  logic [WB-1:0] wa, imm, x;
  logic [5:0]    op6;

  // memory
  logic [WB-1:0] mem [MEM_WORDS];
  logic [WB-1:0] rdata;
  logic          mem_we;
  logic [AW-1:0] rd_a, wr_a;
  logic [WB-1:0] mem_wd;

  logic [15:0]   wpc_inc, wsp_inc, push_sp;
  logic [WB-1:0] imm_sc, alu, merged, md_result;
  logic [20:0]   widx;
  logic          widx_ok, op_bad, exec_ok, md_start, md_done;
  logic [BOFF+2:0] sh_lc, sh_sc;
  logic [7:0]    lc_byte;
  kind_t         kind;
  status_t       exec_code, op_code;
  md_op_t        md_mode;

  always_comb begin
    wpc_inc = wpc + STEP;
    wsp_inc = wsp + STEP;
    push_sp = wsp - STEP;
    imm_sc  = imm << BOFF;
    widx    = 21'(word_index);
    widx_ok = widx < 21'(MEM_WORDS);
    kind    = op_kind(op6);
    op_bad  = rdata > WB'(SBM_OP_LAST);
    sh_lc   = {wa[BOFF-1:0], 3'b000};
    sh_sc   = {x[BOFF-1:0], 3'b000};
    lc_byte = 8'(rdata >> sh_lc);
    merged  = (rdata & ~(WB'(8'hFF) << sh_sc)) | (WB'(wa[7:0]) << sh_sc);
  end

  // fault checks of the opcode fetch
  always_comb begin
    priority if (op_bad) op_code = ST_BADOP;
    else if (op_has_imm(rdata[5:0]) && !in_range(AW'(wpc_inc))) op_code = ST_ADDR;
    else if (op_needs_x(rdata[5:0]) && !in_range(AW'(wsp))) op_code = ST_ADDR;
    else op_code = ST_RUN;
  end

  // fault checks of the execute step
  always_comb begin
    unique case (kind)
      K_PUSH:     exec_code = in_range(AW'(push_sp)) ? ST_RUN : ST_ADDR;
      K_LEAVE:    exec_code = in_range(AW'(wbp)) ? ST_RUN : ST_ADDR;
      K_LOAD:     exec_code = in_range(AW'(wa)) ? ST_RUN : ST_ADDR;
      K_SI, K_SC: exec_code = in_range(AW'(x)) ? ST_RUN : ST_ADDR;
      K_DIV:      exec_code = (wa == '0) ? ST_DIVZ : ST_RUN;
      K_SYS:      exec_code = ST_SYS;
      default:    exec_code = ST_RUN;
    endcase
    exec_ok = cmd.exec && (exec_code == ST_RUN);
  end

  // combinational arithmetic and logic
  always_comb begin
    unique case (op6)
      OP_OR:   alu = x | wa;
      OP_XOR:  alu = x ^ wa;
      OP_AND:  alu = x & wa;
      OP_EQ:   alu = WB'(x == wa);
      OP_NE:   alu = WB'(x != wa);
      OP_LT:   alu = WB'($signed(x) < $signed(wa));
      OP_GT:   alu = WB'($signed(wa) < $signed(x));
      OP_LE:   alu = WB'(!($signed(wa) < $signed(x)));
      OP_GE:   alu = WB'(!($signed(x) < $signed(wa)));
      OP_SHL:  alu = x << wa;
      OP_SHR:  alu = WB'($signed(x) >>> wa);
      OP_ADD:  alu = x + wa;
      OP_SUB:  alu = x - wa;
      default: alu = wa;
    endcase
  end

  // memory address and write data selection
  always_comb begin
    rd_a   = AW'(pc);
    wr_a   = AW'(push_sp);
    mem_wd = wa;
    mem_we = 1'b0;
    if (cmd.take_op) begin
      rd_a = op_has_imm(rdata[5:0]) ? AW'(wpc_inc) : AW'(wsp);
    end else if (cmd.exec) begin
      unique case (kind)
        K_LEAVE: rd_a = AW'(wbp);
        K_LOAD:  rd_a = AW'(wa);
        default: rd_a = AW'(x);
      endcase
    end else if (cmd.leave_bp) begin
      rd_a = AW'(wsp_inc);
    end
    if (cmd.write_req) begin
      mem_we = widx_ok;
      wr_a   = AW'({widx, {BOFF{1'b0}}});
      mem_wd = WB'(write_value);
    end else if (exec_ok && (kind == K_PUSH || kind == K_SI)) begin
      mem_we = 1'b1;
      if (op6 == OP_JSR)        mem_wd = WB'(wpc);
      else if (op6 == OP_ENTER) mem_wd = WB'(wbp);
      if (kind == K_SI)         wr_a = AW'(x);
    end else if (cmd.sc_merge) begin
      mem_we = 1'b1;
      wr_a   = AW'(x);
      mem_wd = merged;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_a[BOFF +: IDX]] <= mem_wd;
    rdata <= mem[rd_a[BOFF +: IDX]];
  end

  // iterative multiply and divide
  always_comb begin
    md_start = exec_ok && (kind == K_MUL || kind == K_DIV);
    unique case (op6)
      OP_MUL:  md_mode = MD_MUL;
      OP_DIV:  md_mode = MD_DIV;
      default: md_mode = MD_MOD;
    endcase
  end

  sbm_muldiv #(.WORD_BITS(WORD_BITS)) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (md_start),
    .mode   (md_mode),
    .lhs    (x),
    .rhs    (wa),
    .done   (md_done),
    .result (md_result)
  );

  always_comb begin
    stat.running   = (status == ST_RUN);
    stat.pc_ok     = in_range(AW'(pc));
    stat.op_fault  = (op_code != ST_RUN);
    stat.op_imm    = op_has_imm(rdata[5:0]);
    stat.op_x      = op_needs_x(rdata[5:0]);
    stat.exec_bad  = (exec_code != ST_RUN);
    stat.leave_bad = !in_range(AW'(wsp_inc));
    stat.kind      = kind;
    stat.iter_done = md_done;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_address     <= 16'd0;
      stack_top_address <= 16'd65532;
    end else if (cfg_write) begin
      if (cfg_index) stack_top_address <= cfg_data;
      else           entry_address     <= cfg_data;
    end
  end

  // machine state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= '0;
      sp     <= '0;
      bp     <= '0;
      acc    <= '0;
      exitv  <= '0;
      steps  <= '0;
      status <= ST_RUN;
      opx    <= '0;
    end else begin
      if (cmd.write_req || cmd.start_req || cmd.nop_req || cmd.begin_step) opx <= '0;
      if (cmd.start_req) begin
        pc     <= entry_address;
        sp     <= stack_top_address;
        bp     <= stack_top_address;
        acc    <= '0;
        steps  <= '0;
        status <= ST_RUN;
        exitv  <= '0;
      end
      if (cmd.begin_step && status == ST_RUN) begin
        steps <= steps + 32'd1;
        if (!stat.pc_ok) status <= ST_ADDR;
      end
      if (cmd.take_op) begin
        opx <= rdata[5:0];
        if (op_code != ST_RUN) status <= op_code;
      end
      if (cmd.exec && exec_code != ST_RUN) status <= exec_code;
      if (exec_ok && op6 == OP_EXIT) exitv <= x;
      if (cmd.leave_bp && stat.leave_bad) status <= ST_ADDR;
      if (cmd.commit) begin
        pc     <= wpc;
        acc    <= wa;
        sp     <= wsp;
        bp     <= wbp;
        status <= (op6 == OP_EXIT) ? ST_EXIT : ST_RUN;
      end
    end
  end

  // working registers of the instruction in flight
  always_ff @(posedge clk) begin
    if (cmd.begin_step) begin
      wpc <= pc;
      wsp <= sp;
      wbp <= bp;
      wa  <= acc;
    end
    if (cmd.take_op) begin
      op6 <= rdata[5:0];
      wpc <= wpc_inc;
    end
    if (cmd.take_imm) begin
      imm <= rdata;
      wpc <= wpc_inc;
    end
    if (cmd.take_x) begin
      x <= rdata;
      if (op6 != OP_EXIT) wsp <= wsp_inc;
    end
    if (exec_ok) begin
      unique case (op6)
        OP_LEA:   wa <= WB'(wbp) + imm_sc;
        OP_IMM:   wa <= imm;
        OP_JMP:   wpc <= imm[15:0];
        OP_JSR: begin
          wsp <= push_sp;
          wpc <= imm[15:0];
        end
        OP_BZ:    if (wa == '0) wpc <= imm[15:0];
        OP_BNZ:   if (wa != '0) wpc <= imm[15:0];
        OP_ENTER: begin
          wbp <= push_sp;
          wsp <= push_sp - imm_sc[15:0];
        end
        OP_ADJ:   wsp <= wsp + imm_sc[15:0];
        OP_LEAVE: wsp <= wbp;
        OP_PSH:   wsp <= push_sp;
        default:  wa <= alu;
      endcase
    end
    if (cmd.leave_bp) begin
      wbp <= rdata[15:0];
      wsp <= wsp_inc;
    end
    if (cmd.leave_pc) begin
      wpc <= rdata[15:0];
      wsp <= wsp_inc;
    end
    if (cmd.load_data) begin
      wa <= (op6 == OP_LI) ? rdata : WB'($signed(lc_byte));
    end
    if (cmd.sc_merge) wa <= WB'($signed(wa[7:0]));
    if (cmd.iter_end) wa <= md_result;
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      program_counter <= pc;
      accumulator     <= 32'(acc);
      stack_pointer   <= sp;
      frame_pointer   <= bp;
      run_status      <= status;
      exit_value      <= 32'(exitv);
      executed_opcode <= opx;
      steps_taken     <= steps;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/stack_bytecode_machine_core.sv -----
`default_nettype none
// Bytecode machine with accumulator, downward stack and frame pointer in one
// word memory with one write port and one registered read port. Every
// transaction (write word, start, step, no-op) gives one result. A step is
// opcode fetch, immediate or operand read if needed, execute and commit,
// with extra reads for LEAVE, LI and LC, a merge write for SC and a wait on
// the bit-serial multiply/divide unit for MUL, DIV and MOD. Faults end the
// step early, and a step on a halted machine goes straight to its result.
// Memory reads, one per sequencer state, set the step time, which a stalled
// result extends. A new transaction is taken while the last result waits.
// The memory holds undefined values until written; nothing clears it.
module stack_bytecode_machine_core
  import sbm_pkg::*;
#(
  parameter int MEM_WORDS = SBM_MEM_WORDS,
  parameter int WORD_BITS = SBM_WORD_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  req_type,
  input  wire logic [13:0] word_index,
  input  wire logic signed [31:0] write_value,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      program_counter,
  output logic signed [31:0] accumulator,
  output logic [15:0]      stack_pointer,
  output logic [15:0]      frame_pointer,
  output logic [2:0]       run_status,
  output logic signed [31:0] exit_value,
  output logic [5:0]       executed_opcode,
  output logic [31:0]      steps_taken
);

  cmd_t  cmd;
  stat_t stat;

  sbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sbm_datapath #(
    .MEM_WORDS (MEM_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .word_index      (word_index),
    .write_value     (write_value),
    .program_counter (program_counter),
    .accumulator     (accumulator),
    .stack_pointer   (stack_pointer),
    .frame_pointer   (frame_pointer),
    .run_status      (run_status),
    .exit_value      (exit_value),
    .executed_opcode (executed_opcode),
    .steps_taken     (steps_taken)
  );

  // one transaction at a time through the sequencer
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction accepted while busy");

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (run_status <= ST_ADDR))
    else $error("undefined run status");

  // exit value only reported once the machine has exited
  a_exit_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && run_status != ST_EXIT) |-> (exit_value == 32'sd0))
    else $error("exit value without exit");

  // commit is never asserted twice in a row
  a_commit_order: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> cmd.out_load || !cmd.commit)
    else $error("commit sequencing broken");

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
  import sbm_pkg::*;

  localparam logic CFG_ENTRY     = 1'b0;
  localparam logic CFG_STACK_TOP = 1'b1;

  typedef struct packed {
    logic [15:0] pc;
    logic [31:0] acc;
    logic [15:0] sp;
    logic [15:0] bp;
    logic [2:0]  status;
    logic [31:0] exitv;
    logic [5:0]  opcode;
    logic [31:0] steps;
  } machine_view_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [13:0] word_index;
  logic [31:0] write_value;
  logic        cfg_write;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] program_counter;
  logic [31:0] accumulator;
  logic [15:0] stack_pointer;
  logic [15:0] frame_pointer;
  logic [2:0]  run_status;
  logic [31:0] exit_value;
  logic [5:0]  executed_opcode;
  logic [31:0] steps_taken;

  // mirror of the machine
  logic [31:0] mem_words [SBM_MEM_WORDS];
  bit          written_map [SBM_MEM_WORDS];
  logic [15:0] pc_q, sp_q, bp_q, entry_cfg, stack_cfg;
  logic [31:0] acc_q, steps_q, exit_q;
  logic [2:0]  status_q;
  bit          probing;
  logic [13:0] need_fill [$];

  machine_view_t expected_views [$];
  machine_view_t want;
  int unsigned   fails, sent_count, steps_sent, exits_seen, faults_seen;
  bit            calm;

  stack_bytecode_machine_core u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .word_index(word_index), .write_value(write_value),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .program_counter(program_counter), .accumulator(accumulator),
    .stack_pointer(stack_pointer), .frame_pointer(frame_pointer),
    .run_status(run_status), .exit_value(exit_value),
    .executed_opcode(executed_opcode), .steps_taken(steps_taken)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  // word read, noting words that would be read before ever being written
  function automatic logic [31:0] fetch_word(input logic [15:0] addr);
    logic [13:0] idx;
    idx = addr[15:2];
    if (probing && !written_map[idx]) need_fill.push_back(idx);
    return mem_words[idx];
  endfunction

  function automatic void store_word(input logic [15:0] addr, input logic [31:0] val);
    if (!probing) begin
      mem_words[addr[15:2]] = val;
      written_map[addr[15:2]] = 1'b1;
    end
  endfunction

  // one instruction; with commit low only the reads are traced
  function automatic logic [5:0] run_instr(input bit commit);
    logic [15:0] p, s, b;
    logic [31:0] a, op, imm, x, w;
    logic [4:0]  lane;
    logic [2:0]  st;
    p = pc_q; s = sp_q; b = bp_q; a = acc_q; imm = '0; x = '0; st = ST_RUN;
    probing = !commit;
    if (commit) steps_q = steps_q + 1;
    op = fetch_word(p);
    p = p + 16'd4;
    if (op > SBM_OP_LAST) begin
      if (commit) status_q = ST_BADOP;
      return op[5:0];
    end
    if (op <= OP_ADJ) begin
      imm = fetch_word(p);
      p = p + 16'd4;
    end
    // operations that pop the left operand, plus leave and exit
    if (op == OP_LEAVE || op == OP_SI || op == OP_SC || op == OP_EXIT ||
        (op >= OP_OR && op <= OP_MOD)) begin
      x = fetch_word(s);
      if (op != OP_EXIT) s = s + 16'd4;
    end
    case (op[5:0])
      OP_LEA: a = {16'd0, b} + (imm << 2);
      OP_IMM: a = imm;
      OP_JMP: p = imm[15:0];
      OP_JSR: begin
        s = s - 16'd4;
        store_word(s, {16'd0, p});
        p = imm[15:0];
      end
      OP_BZ:  if (a == 0) p = imm[15:0];
      OP_BNZ: if (a != 0) p = imm[15:0];
      OP_ENTER: begin
        s = s - 16'd4;
        store_word(s, {16'd0, b});
        b = s;
        s = s - {imm[13:0], 2'b00};
      end
      OP_ADJ: s = s + {imm[13:0], 2'b00};
      OP_LEAVE: begin
        s = b;
        w = fetch_word(s);
        b = w[15:0];
        s = s + 16'd4;
        w = fetch_word(s);
        p = w[15:0];
        s = s + 16'd4;
      end
      OP_LI: begin
        if (a[31:16] != 0) st = ST_ADDR;
        else a = fetch_word(a[15:0]);
      end
      OP_LC: begin
        if (a[31:16] != 0) st = ST_ADDR;
        else begin
          lane = {a[1:0], 3'b000};
          w = fetch_word(a[15:0]) >> lane;
          a = {{24{w[7]}}, w[7:0]};
        end
      end
      OP_SI: begin
        if (x[31:16] != 0) st = ST_ADDR;
        else store_word(x[15:0], a);
      end
      OP_SC: begin
        if (x[31:16] != 0) st = ST_ADDR;
        else begin
          lane = {x[1:0], 3'b000};
          w = fetch_word(x[15:0]);
          w = (w & ~(32'hff << lane)) | ({24'd0, a[7:0]} << lane);
          store_word(x[15:0], w);
          a = {{24{a[7]}}, a[7:0]};
        end
      end
      OP_PSH: begin
        s = s - 16'd4;
        store_word(s, a);
      end
      OP_OR:  a = x | a;
      OP_XOR: a = x ^ a;
      OP_AND: a = x & a;
      OP_EQ:  a = {31'd0, x == a};
      OP_NE:  a = {31'd0, x != a};
      OP_LT:  a = {31'd0, $signed(x) < $signed(a)};
      OP_GT:  a = {31'd0, $signed(x) > $signed(a)};
      OP_LE:  a = {31'd0, $signed(x) <= $signed(a)};
      OP_GE:  a = {31'd0, $signed(x) >= $signed(a)};
      OP_SHL: a = (a >= 32) ? 32'd0 : (x << a[4:0]);
      OP_SHR: a = (a >= 32) ? {32{x[31]}} : 32'($signed(x) >>> a[4:0]);
      OP_ADD: a = x + a;
      OP_SUB: a = x - a;
      OP_MUL: a = x * a;
      OP_DIV, OP_MOD: begin
        if (a == 0) st = ST_DIVZ;
        // most negative over minus one wraps to itself, remainder zero
        else if (x == 32'h8000_0000 && a == 32'hffff_ffff)
          a = (op == OP_DIV) ? x : 32'd0;
        else if (op == OP_DIV) a = $signed(x) / $signed(a);
        else a = $signed(x) % $signed(a);
      end
      OP_EXIT: begin
        st = ST_EXIT;
        if (commit) exit_q = x;
      end
      default: st = ST_SYS;
    endcase
    if (commit) begin
      status_q = st;
      if (st == ST_RUN || st == ST_EXIT) begin
        pc_q = p; acc_q = a; sp_q = s; bp_q = b;
      end
    end
    return op[5:0];
  endfunction

  // effect of one request on the mirror, giving the expected result
  function automatic machine_view_t apply_request(input req_t req, input logic [13:0] idx,
                                                  input logic [31:0] val);
    logic [5:0] opx;
    opx = '0;
    case (req)
      REQ_WRITE: begin
        mem_words[idx] = val;
        written_map[idx] = 1'b1;
      end
      REQ_START: begin
        pc_q = entry_cfg; sp_q = stack_cfg; bp_q = stack_cfg;
        acc_q = '0; steps_q = '0; status_q = ST_RUN; exit_q = '0;
      end
      REQ_STEP: begin
        if (status_q == ST_RUN) begin
          opx = run_instr(1'b1);
          steps_sent++;
          if (status_q == ST_EXIT) exits_seen++;
          else if (status_q != ST_RUN) faults_seen++;
        end
      end
      default: ;
    endcase
    return '{pc_q, acc_q, sp_q, bp_q, status_q, exit_q, opx, steps_q};
  endfunction

  // one transaction on the request channel
  task automatic issue(input req_t req, input logic [13:0] idx, input logic [31:0] val);
    int gap;
    expected_views.push_back(apply_request(req, idx, val));
    sent_count++;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    req_type    <= req;
    word_index  <= idx;
    write_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and let every outstanding result come back
  task automatic settle();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (expected_views.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    if (index == CFG_ENTRY) entry_cfg = data;
    else stack_cfg = data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] filler_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, SBM_OP_LAST);
      2: return 32'($urandom_range(0, 16)) - 32'd8;
      3: return $urandom_range(0, 65535);
      4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom_range(0, 63);
    endcase
  endfunction

  // step, first writing any word the instruction would read unwritten
  task automatic step_machine();
    int round;
    for (round = 0; round < 8 && status_q == ST_RUN; round++) begin
      need_fill.delete();
      void'(run_instr(1'b0));
      if (need_fill.size() == 0) break;
      foreach (need_fill[i])
        if (!written_map[need_fill[i]]) issue(REQ_WRITE, need_fill[i], filler_word());
    end
    issue(REQ_STEP, 14'($urandom), $urandom);
  endtask

  function automatic logic [31:0] operand_for(input logic [5:0] op, input int len);
    case (op)
      OP_JMP, OP_JSR, OP_BZ, OP_BNZ:
        return {16'd0, entry_cfg + 16'(4 * $urandom_range(0, 2 * len))};
      OP_LEA, OP_ADJ, OP_ENTER: return 32'($urandom_range(0, 8)) - 32'd4;
      default:
        case ($urandom_range(0, 7))
          0: return 32'd0;
          1: return 32'hffff_ffff;
          2: return 32'h8000_0000;
          3: return 32'h7fff_ffff;
          4: return $urandom_range(0, 40);
          5: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_fff0;
          6: return {16'd0, stack_cfg - 16'($urandom_range(0, 32))};
          default: return $urandom_range(0, 65535);
        endcase
    endcase
  endfunction

  task automatic load_program(input int len);
    logic [13:0] w;
    logic [5:0]  op;
    int          r;
    w = entry_cfg[15:2];
    for (int k = 0; k < len; k++) begin
      r = $urandom_range(0, 99);
      if (r < 3) op = OP_EXIT;
      else if (r < 6) op = 6'($urandom_range(OP_SYS_FIRST, 63));
      else op = 6'($urandom_range(0, OP_MOD));
      issue(REQ_WRITE, w, {26'd0, op});
      w = w + 1;
      if (op <= OP_ADJ) begin
        issue(REQ_WRITE, w, operand_for(op, len));
        w = w + 1;
      end
    end
  endtask

  // result channel back-pressure
  initial begin
    int n;
    out_stall <= 1'b0;
    @(negedge rst);
    forever begin
      n = calm ? 0 : $urandom_range(0, 7);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      fails++;
    end
  endfunction

  // compare every accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_views.size() == 0) begin
        $error("result with no transaction outstanding");
        fails++;
      end else begin
        want = expected_views.pop_front();
        check_field("program_counter", want.pc, program_counter);
        check_field("accumulator", want.acc, accumulator);
        check_field("stack_pointer", want.sp, stack_pointer);
        check_field("frame_pointer", want.bp, frame_pointer);
        check_field("run_status", want.status, run_status);
        check_field("exit_value", want.exitv, exit_value);
        check_field("executed_opcode", want.opcode, executed_opcode);
        check_field("steps_taken", want.steps, steps_taken);
      end
    end
  end

  task automatic test_reset_view();
    issue(REQ_NOP, 14'h3fff, 32'hffff_ffff);
    settle();
  endtask

  // divide by zero, halted step, field extremes
  task automatic test_directed_program();
    write_reg(CFG_ENTRY, 16'h0100);
    write_reg(CFG_STACK_TOP, 16'h0200);
    issue(REQ_WRITE, 14'd0, 32'h8000_0000);
    issue(REQ_WRITE, 14'h3fff, 32'h7fff_ffff);
    issue(REQ_WRITE, 14'd64, {26'd0, OP_IMM});
    issue(REQ_WRITE, 14'd65, 32'd7);
    issue(REQ_WRITE, 14'd66, {26'd0, OP_PSH});
    issue(REQ_WRITE, 14'd67, {26'd0, OP_IMM});
    issue(REQ_WRITE, 14'd68, 32'd0);
    issue(REQ_WRITE, 14'd69, {26'd0, OP_DIV});
    issue(REQ_START, 14'd0, 32'd0);
    repeat (5) step_machine();
    issue(REQ_NOP, 14'd0, 32'd0);
    settle();
  endtask

  task automatic test_random_programs();
    int phase, len, nsteps;
    phase = 0;
    while (sent_count < 1150) begin
      settle();
      calm = ($urandom_range(0, 4) == 0);
      if (phase == 0) begin
        write_reg(CFG_ENTRY, 16'h0000);
        write_reg(CFG_STACK_TOP, 16'hffff);
      end else if (phase == 1) begin
        write_reg(CFG_ENTRY, 16'hfffc);
        write_reg(CFG_STACK_TOP, 16'h0000);
      end else if ($urandom_range(0, 1)) begin
        write_reg(CFG_ENTRY, 16'($urandom_range(0, 16383) * 4));
        write_reg(CFG_STACK_TOP, $urandom_range(0, 1) ? 16'hfffc : 16'($urandom));
      end
      len = $urandom_range(4, 16);
      load_program(len);
      issue(REQ_START, 14'($urandom), $urandom);
      nsteps = $urandom_range(8, 30);
      for (int k = 0; k < nsteps; k++) begin
        case ($urandom_range(0, 19))
          0: issue(REQ_NOP, 14'($urandom), $urandom);
          1: issue(REQ_START, 14'($urandom), $urandom);
          // hold off until the block has drained
          2: begin
            in_valid <= 1'b0;
            while (expected_views.size() != 0) @(posedge clk);
            step_machine();
          end
          default: step_machine();
        endcase
      end
      phase++;
    end
    calm = 1'b0;
    settle();
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    req_type    <= REQ_NOP;
    word_index  <= '0;
    write_value <= '0;
    cfg_write   <= 1'b0;
    cfg_index   <= CFG_ENTRY;
    cfg_data    <= '0;
    pc_q = '0; sp_q = '0; bp_q = '0; acc_q = '0; steps_q = '0; exit_q = '0;
    status_q = ST_RUN; entry_cfg = 16'h0000; stack_cfg = 16'hfffc;
    calm = 1'b0; probing = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_view();
    test_directed_program();
    test_random_programs();
    if (expected_views.size() != 0) begin
      $error("%0d results never arrived", expected_views.size());
      fails++;
    end
    $display("covered %0d transactions with %0d executed instructions,", sent_count,
             steps_sent);
    $display("%0d programs ending in exit and %0d ending in a fault", exits_seen,
             faults_seen);
    if (fails == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sbm_pkg.sv
rtl/sbm_muldiv.sv
rtl/sbm_ctrl.sv
rtl/sbm_datapath.sv
rtl/stack_bytecode_machine_core.sv
bench/tb_top.sv
